### rtl/core/vcr_pkg.sv
// ----------------------------------------------------------------------------
// vcr_pkg
// Shared constants and types for the visual color resolver.
// ----------------------------------------------------------------------------
package vcr_pkg;

    localparam int CHANNEL_WIDTH = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_VISUAL_CLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_RGB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        VC_STATIC_GRAY  = 3'd0,
        VC_GRAY_SCALE   = 3'd1,
        VC_STATIC_COLOR = 3'd2,
        VC_PSEUDO_COLOR = 3'd3,
        VC_TRUE_COLOR   = 3'd4,
        VC_DIRECT_COLOR = 3'd5
    } t_visual_class;

    localparam logic [2:0] RST_VISUAL_CLASS = 3'd3;
    localparam logic [4:0] RST_BITS_PER_RGB = 5'd8;
    localparam logic [5:0] RST_PLANE_COUNT  = 6'd24;

    // luma weights, in percent
    localparam int LUMA_WR  = 30;
    localparam int LUMA_WG  = 59;
    localparam int LUMA_WB  = 11;
    localparam int LUMA_DIV = 100;

endpackage

### rtl/core/vcr_pix_if.sv
// ----------------------------------------------------------------------------
// vcr_pix_if
// Valid/ready channel carrying one requested RGB triple per item.
// ----------------------------------------------------------------------------
interface vcr_pix_if #(
    parameter int W = vcr_pkg::CHANNEL_WIDTH
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] red_in;
    logic [W-1:0] green_in;
    logic [W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

### rtl/core/vcr_res_if.sv
// ----------------------------------------------------------------------------
// vcr_res_if
// Valid/ready channel carrying one resolved RGB triple per item.
// ----------------------------------------------------------------------------
interface vcr_res_if #(
    parameter int W = vcr_pkg::CHANNEL_WIDTH
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] red_out;
    logic [W-1:0] green_out;
    logic [W-1:0] blue_out;
    logic         config_error;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output config_error, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input config_error, output ready);
endinterface

### rtl/core/vcr_front.sv
// ----------------------------------------------------------------------------
// vcr_front
// Two register stages: weighted RGB sum, then luma by reciprocal multiply.
// ----------------------------------------------------------------------------
module vcr_front #(
    parameter int W = vcr_pkg::CHANNEL_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_en_1,
    input  logic         i_en_2,
    input  logic [W-1:0] i_red,
    input  logic [W-1:0] i_green,
    input  logic [W-1:0] i_blue,
    output logic [W-1:0] o_red,
    output logic [W-1:0] o_green,
    output logic [W-1:0] o_blue,
    output logic [W-1:0] o_luma
);
    // sum < 100 * 2^W; reciprocal exact while sum * error < 2^SHIFT
    localparam int SW    = W + 7;
    localparam int RW    = W + 8;
    localparam int SHIFT = W + 14;
    localparam int PW    = SW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SHIFT) + 64'(vcr_pkg::LUMA_DIV) - 64'd1) / 64'(vcr_pkg::LUMA_DIV));

    logic [W-1:0]  r_red_1, r_green_1, r_blue_1;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] n_sum;
    logic [W-1:0]  r_red_2, r_green_2, r_blue_2;
    logic [W-1:0]  r_luma;
    logic [PW-1:0] prod;

    assign n_sum = SW'(i_red)   * SW'(vcr_pkg::LUMA_WR)
                 + SW'(i_green) * SW'(vcr_pkg::LUMA_WG)
                 + SW'(i_blue)  * SW'(vcr_pkg::LUMA_WB);

    assign prod = PW'(r_sum) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en_1) begin
            r_red_1   <= i_red;
            r_green_1 <= i_green;
            r_blue_1  <= i_blue;
            r_sum     <= n_sum;
        end
        if (i_en_2) begin
            r_red_2   <= r_red_1;
            r_green_2 <= r_green_1;
            r_blue_2  <= r_blue_1;
            r_luma    <= prod[SHIFT +: W];
        end
    end

    assign o_red   = r_red_2;
    assign o_green = r_green_2;
    assign o_blue  = r_blue_2;
    assign o_luma  = r_luma;
endmodule

### rtl/core/vcr_rescale.sv
// ----------------------------------------------------------------------------
// vcr_rescale
// Two-stage quantize and full-scale rescale of one channel.
// q * (2^W-1) / (2^b-1) is the b-bit code repeated over W bits, less one
// when the code window that follows is below the code itself.
// ----------------------------------------------------------------------------
module vcr_rescale #(
    parameter int W = vcr_pkg::CHANNEL_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_en_a,
    input  logic                   i_en_b,
    input  logic [W-1:0]           i_val,
    input  logic [$clog2(W+1)-1:0] i_bits,
    output logic [W-1:0]           o_val
);
    localparam int BW   = $clog2(W + 1);
    localparam int PW   = 2 * W;
    localparam int NS   = $clog2(PW);
    localparam int HALF = NS / 2;
    localparam int SHW  = BW + NS;

    logic [W-1:0]  mask;
    logic [W-1:0]  n_a;
    logic [PW-1:0] n_rep;
    logic [W-1:0]  r_a;
    logic [PW-1:0] r_rep;
    logic [PW-1:0] rep_b;
    logic [W-1:0]  hi;
    logic [W-1:0]  lo;
    logic [W-1:0]  n_q;
    logic [W-1:0]  r_q;

    // top b bits kept
    assign mask = ~({W{1'b1}} >> i_bits);
    assign n_a  = i_val & mask;

    always_comb begin
        logic [SHW-1:0] sh;
        n_rep = {n_a, W'(0)};
        for (int k = 0; k < HALF; k++) begin
            sh    = SHW'(i_bits) << k;
            n_rep = n_rep | (n_rep >> sh);
        end
    end

    always_comb begin
        logic [SHW-1:0] sh;
        rep_b = r_rep;
        for (int k = HALF; k < NS; k++) begin
            sh    = SHW'(i_bits) << k;
            rep_b = rep_b | (rep_b >> sh);
        end
    end

    assign hi  = rep_b[PW-1:W];
    assign lo  = rep_b[W-1:0] & mask;
    assign n_q = (lo < r_a) ? hi - W'(1) : hi;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_a   <= n_a;
            r_rep <= n_rep;
        end
        if (i_en_b) begin
            r_q <= n_q;
        end
    end

    assign o_val = r_q;
endmodule

### rtl/core/visual_color_resolver.sv
// ----------------------------------------------------------------------------
// visual_color_resolver
// Resolve an RGB triple to the nearest color of the configured visual and
// rescale each channel to full range.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one requested triple per item, o_res one resolved triple
//   plus config_error per item; both are valid/ready channels.
//   Configure through i_cfg_we/i_cfg_idx/i_cfg_data only while the block is
//   idle: 0 visual class, 1 bits per RGB, 2 plane count.
// Pipeline: four register stages (sum, luma divide, replicate first half,
//   replicate second half and correct); items pass through them
//   in order before o_res.valid rises.
// Throughput: one item per cycle while unstalled; one item per stage.
// Stall: while o_res.ready is low the output stage holds; earlier stages keep
//   filling bubbles, and i_pix.ready drops only once every stage is full.
// Reset: all valid bits clear, config registers return to pseudo color,
//   8 bits per channel, 24 planes.
// config_error rises (static/true color, unused codes) when the blue width
//   plane_count - 2*bits lies outside 1..CHANNEL_WIDTH; blue is then 0.
// ----------------------------------------------------------------------------
module visual_color_resolver #(
    parameter int CHANNEL_WIDTH = vcr_pkg::CHANNEL_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vcr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vcr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vcr_pix_if.sink                         i_pix,
    vcr_res_if.source                       o_res
);
    localparam int W  = CHANNEL_WIDTH;
    localparam int BW = $clog2(W + 1);
    localparam int NSTG = 4;

    // ---------------- configuration registers ----------------
    logic [2:0] r_visual_class;
    logic [4:0] r_bits_per_rgb;
    logic [5:0] r_plane_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visual_class <= vcr_pkg::RST_VISUAL_CLASS;
            r_bits_per_rgb <= vcr_pkg::RST_BITS_PER_RGB;
            r_plane_count  <= vcr_pkg::RST_PLANE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vcr_pkg::CFG_VISUAL_CLASS: r_visual_class <= i_cfg_data[2:0];
                vcr_pkg::CFG_BITS_PER_RGB: r_bits_per_rgb <= i_cfg_data[4:0];
                vcr_pkg::CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- derived configuration ----------------
    // Users hold config static with items in flight (unchecked); decode once.
    logic              is_gray;
    logic              is_pseudo;
    logic [BW-1:0]     w_eff;
    logic signed [7:0] blue_w;
    logic              blue_bad;
    logic              cfg_err;
    logic [BW-1:0]     blue_bits;

    always_comb begin
        is_gray   = 1'b0;
        is_pseudo = 1'b0;
        unique case (r_visual_class) inside
            vcr_pkg::VC_STATIC_GRAY,
            vcr_pkg::VC_GRAY_SCALE:   is_gray   = 1'b1;
            vcr_pkg::VC_PSEUDO_COLOR,
            vcr_pkg::VC_DIRECT_COLOR: is_pseudo = 1'b1;
            default: ;  // static/true color and unused codes split blue off
        endcase
    end

    // clamp bits per channel to 1..W
    always_comb begin
        if (r_bits_per_rgb == 5'd0) begin
            w_eff = BW'(1);
        end else if (6'(r_bits_per_rgb) > 6'(W)) begin
            w_eff = BW'(W);
        end else begin
            w_eff = BW'(r_bits_per_rgb);
        end
    end

    assign blue_w    = $signed(8'(r_plane_count)) - $signed(8'(w_eff) << 1);
    assign blue_bad  = (blue_w < 8'sd1) || (blue_w > $signed(8'(W)));
    assign cfg_err   = !is_gray && !is_pseudo && blue_bad;
    // a bad blue width still feeds a legal width; the result is zeroed later
    assign blue_bits = (is_gray || is_pseudo || blue_bad) ? w_eff : BW'(blue_w);

    // ---------------- pipeline control ----------------
    // Each stage loads when empty or when the stage after it moves.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // ---------------- datapath ----------------
    logic [W-1:0] f_red, f_green, f_blue, f_luma;
    logic [W-1:0] sel_red, sel_green, sel_blue;
    logic [W-1:0] q_red, q_green, q_blue;

    vcr_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_en_1  (en[0]),
        .i_en_2  (en[1]),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_red   (f_red),
        .o_green (f_green),
        .o_blue  (f_blue),
        .o_luma  (f_luma)
    );

    // gray visuals quantize the luma on all three channels
    assign sel_red   = is_gray ? f_luma : f_red;
    assign sel_green = is_gray ? f_luma : f_green;
    assign sel_blue  = is_gray ? f_luma : f_blue;

    vcr_rescale #(.W(W)) u_rescale_r (
        .i_clk  (i_clk),
        .i_en_a (en[2]),
        .i_en_b (en[3]),
        .i_val  (sel_red),
        .i_bits (w_eff),
        .o_val  (q_red)
    );

    vcr_rescale #(.W(W)) u_rescale_g (
        .i_clk  (i_clk),
        .i_en_a (en[2]),
        .i_en_b (en[3]),
        .i_val  (sel_green),
        .i_bits (w_eff),
        .o_val  (q_green)
    );

    vcr_rescale #(.W(W)) u_rescale_b (
        .i_clk  (i_clk),
        .i_en_a (en[2]),
        .i_en_b (en[3]),
        .i_val  (sel_blue),
        .i_bits (blue_bits),
        .o_val  (q_blue)
    );

    assign o_res.valid        = r_vld[NSTG-1];
    assign o_res.red_out      = q_red;
    assign o_res.green_out    = q_green;
    assign o_res.blue_out     = cfg_err ? '0 : q_blue;
    assign o_res.config_error = cfg_err;

    // ---------------- assertions ----------------
    a_err_blue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.config_error |-> o_res.blue_out == '0)
        else $error("config_error with nonzero blue");

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (r_visual_class == vcr_pkg::VC_STATIC_GRAY ||
                        r_visual_class == vcr_pkg::VC_GRAY_SCALE)
        |-> o_res.red_out == o_res.green_out && o_res.green_out == o_res.blue_out)
        else $error("gray result channels differ");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && !o_res.ready |=> r_vld[NSTG-1])
        else $error("output item dropped under stall");
endmodule
